### sv/positional_array_table_defines.svh
// ----------------------------------------------------------------------------
// Positional array table assertion macros
// Shorthand for clocked assertions that are switched off during reset.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_ARRAY_TABLE_DEFINES_SVH
`define POSITIONAL_ARRAY_TABLE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PAT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PAT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/pat_pkg.sv
// ----------------------------------------------------------------------------
// Positional array table package
// Widths, codes, controller states and the command and status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package pat_pkg;

  localparam int DEPTH        = 64;
  localparam int DATA_W       = 32;
  localparam int IDX_W        = $clog2(DEPTH);
  localparam int CNT_W        = $clog2(DEPTH + 1);
  localparam int OP_W         = 2;
  localparam int POS_W        = 7;
  localparam int ST_W         = 2;
  localparam int IN_FIELDS_W  = POS_W + DATA_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = DATA_W + IDX_W + CNT_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT  = 2'd0,
    OP_DELETE  = 2'd1,
    OP_SEARCH  = 2'd2,
    OP_DISPLAY = 2'd3
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2,
    ST_NONE    = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DECIDE,
    S_INS_RD,
    S_INS_WR,
    S_DEL_RD0,
    S_DEL_HOLD,
    S_DEL_RD,
    S_DEL_WR,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_MATCH_RD,
    S_MATCH_CHK,
    S_DISP_RD,
    S_DISP_CHK,
    S_RESP
  } state_t;

  // Read address choice relative to the walking pointer.
  typedef enum logic [1:0] {
    RA_PTR,
    RA_PTR_M1,
    RA_PTR_P1
  } rd_addr_t;

  // Kind of result word loaded into the output register.
  typedef enum logic [2:0] {
    RES_BAD_POS,
    RES_FULL,
    RES_NOT_FOUND,
    RES_EMPTY,
    RES_INSERTED,
    RES_DELETED,
    RES_MATCH,
    RES_ENTRY
  } res_t;

  typedef struct packed {
    logic     take_item;
    logic     setup;
    logic     rd_en;
    rd_addr_t rd_addr;
    logic     wr_shift;
    logic     wr_new;
    logic     ptr_inc;
    logic     ptr_dec;
    logic     ptr_clr;
    logic     hold_removed;
    logic     scan_note;
    logic     cnt_inc;
    logic     cnt_dec;
    logic     emit;
    res_t     res;
  } pat_cmd_t;

  typedef struct packed {
    op_t  op;
    logic pos_zero;
    logic pos_past;
    logic full;
    logic empty;
    logic ptr_above_slot;
    logic ptr_at_end;
    logic hit;
    logic hit_last;
    logic found;
    logic out_free;
  } pat_stat_t;

endpackage

`default_nettype wire

### sv/pat_dp.sv
// ----------------------------------------------------------------------------
// Positional array table datapath
// Entry memory, element count, walking pointer and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pat_dp (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [pat_pkg::OP_W-1:0]    in_op,
  input  wire logic [pat_pkg::IN_DATA_W-1:0] in_data,
  input  wire pat_pkg::pat_cmd_t           cmd,
  output pat_pkg::pat_stat_t               stat,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [pat_pkg::OUT_DATA_W-1:0]   out_data,
  output logic                             out_last,
  output logic [pat_pkg::ST_W-1:0]         out_status
);
  import pat_pkg::*;

  // Latched request.
  op_t               op;
  logic [POS_W-1:0]  pos;
  logic [DATA_W-1:0] val;

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  ptr;
  logic [CNT_W-1:0]  slot;
  logic [IDX_W-1:0]  lastmatch;
  logic              found;
  logic [DATA_W-1:0] removed;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data;
  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic              wr_en;

  logic [CNT_W-1:0]  ptr_m1;
  logic [CNT_W-1:0]  ptr_p1;
  logic [POS_W-1:0]  pos_m1;
  logic [CNT_W-1:0]  ins_slot;

  logic [DATA_W-1:0] out_value;
  logic [IDX_W-1:0]  out_index;
  logic [CNT_W-1:0]  out_count;

  assign ptr_m1   = ptr - CNT_W'(1);
  assign ptr_p1   = ptr + CNT_W'(1);
  assign pos_m1   = pos - POS_W'(1);
  assign ins_slot = (pos_m1 > POS_W'(count)) ? count : CNT_W'(pos_m1);

  always_comb begin
    case (cmd.rd_addr)
      RA_PTR_M1: rd_addr = ptr_m1[IDX_W-1:0];
      RA_PTR_P1: rd_addr = ptr_p1[IDX_W-1:0];
      default:   rd_addr = ptr[IDX_W-1:0];
    endcase
  end

  assign wr_en   = cmd.wr_shift | cmd.wr_new;
  assign wr_addr = cmd.wr_new ? slot[IDX_W-1:0] : ptr[IDX_W-1:0];
  assign wr_data = cmd.wr_new ? val : rd_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      op  <= op_t'(in_op);
      pos <= in_data[POS_W-1:0];
      val <= in_data[POS_W +: DATA_W];
    end
    if (cmd.setup) begin
      found <= 1'b0;
      case (op)
        OP_INSERT: begin
          slot <= ins_slot;
          ptr  <= count;
        end
        OP_DELETE: begin
          slot <= CNT_W'(pos_m1);
          ptr  <= CNT_W'(pos_m1);
        end
        default: begin
          slot <= '0;
          ptr  <= '0;
        end
      endcase
    end else if (cmd.ptr_clr) begin
      ptr <= '0;
    end else if (cmd.ptr_inc) begin
      ptr <= ptr_p1;
    end else if (cmd.ptr_dec) begin
      ptr <= ptr_m1;
    end
    if (cmd.scan_note && stat.hit) begin
      found     <= 1'b1;
      lastmatch <= ptr[IDX_W-1:0];
    end
    if (cmd.hold_removed) begin
      removed <= rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.cnt_inc) begin
      count <= count + CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      count <= count - CNT_W'(1);
    end
  end

  always_comb begin
    stat.op             = op;
    stat.pos_zero       = (pos == '0);
    stat.pos_past       = (pos > POS_W'(count));
    stat.full           = (count == CNT_W'(DEPTH));
    stat.empty          = (count == '0);
    stat.ptr_above_slot = (ptr > slot);
    stat.ptr_at_end     = (ptr_p1 == count);
    stat.hit            = (rd_data == val);
    stat.hit_last       = (ptr[IDX_W-1:0] == lastmatch);
    stat.found          = found;
    stat.out_free       = !out_valid || out_ready;
  end

  // Output register: loaded on emit, cleared once the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_count <= count;
      case (cmd.res)
        RES_BAD_POS: begin
          out_value <= '0; out_index <= '0; out_status <= ST_BAD_POS; out_last <= 1'b1;
        end
        RES_FULL: begin
          out_value <= '0; out_index <= '0; out_status <= ST_FULL; out_last <= 1'b1;
        end
        RES_NOT_FOUND: begin
          out_value <= val; out_index <= '0; out_status <= ST_NONE; out_last <= 1'b1;
        end
        RES_EMPTY: begin
          out_value <= '0; out_index <= '0; out_status <= ST_NONE; out_last <= 1'b1;
        end
        RES_INSERTED: begin
          out_value  <= val;
          out_index  <= slot[IDX_W-1:0];
          out_status <= ST_OK;
          out_last   <= 1'b1;
        end
        RES_DELETED: begin
          out_value  <= removed;
          out_index  <= slot[IDX_W-1:0];
          out_status <= ST_OK;
          out_last   <= 1'b1;
        end
        RES_MATCH: begin
          out_value  <= val;
          out_index  <= ptr[IDX_W-1:0];
          out_status <= ST_OK;
          out_last   <= stat.hit_last;
        end
        default: begin
          out_value  <= rd_data;
          out_index  <= ptr[IDX_W-1:0];
          out_status <= ST_OK;
          out_last   <= stat.ptr_at_end;
        end
      endcase
    end
  end

  assign out_data = {{OUT_PAD_W{1'b0}}, out_count, out_index, out_value};

endmodule

`default_nettype wire

### sv/pat_ctrl.sv
// ----------------------------------------------------------------------------
// Positional array table controller
// Sequences the memory walks for insert, delete, search and display.
// ----------------------------------------------------------------------------
`default_nettype none

module pat_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire pat_pkg::pat_stat_t stat,
  output pat_pkg::pat_cmd_t       cmd
);
  import pat_pkg::*;

  state_t state;
  state_t state_next;
  res_t   res;
  res_t   res_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      res   <= RES_EMPTY;
    end else begin
      state <= state_next;
      res   <= res_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    res_next   = res;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        case (stat.op)
          OP_INSERT: begin
            if (stat.pos_zero) begin
              state_next = S_RESP; res_next = RES_BAD_POS;
            end else if (stat.full) begin
              state_next = S_RESP; res_next = RES_FULL;
            end else begin
              state_next = S_INS_RD;
            end
          end
          OP_DELETE: begin
            if (stat.pos_zero || stat.pos_past) begin
              state_next = S_RESP; res_next = RES_BAD_POS;
            end else begin
              state_next = S_DEL_RD0;
            end
          end
          OP_SEARCH: begin
            if (stat.empty) begin
              state_next = S_RESP; res_next = RES_NOT_FOUND;
            end else begin
              state_next = S_SCAN_RD;
            end
          end
          default: begin
            if (stat.empty) begin
              state_next = S_RESP; res_next = RES_EMPTY;
            end else begin
              state_next = S_DISP_RD;
            end
          end
        endcase
      end
      S_INS_RD: begin
        if (stat.ptr_above_slot) begin
          state_next = S_INS_WR;
        end else begin
          state_next = S_RESP; res_next = RES_INSERTED;
        end
      end
      S_INS_WR:   state_next = S_INS_RD;
      S_DEL_RD0:  state_next = S_DEL_HOLD;
      S_DEL_HOLD: state_next = S_DEL_RD;
      S_DEL_RD: begin
        if (stat.ptr_at_end) begin
          state_next = S_RESP; res_next = RES_DELETED;
        end else begin
          state_next = S_DEL_WR;
        end
      end
      S_DEL_WR:  state_next = S_DEL_RD;
      S_SCAN_RD: state_next = S_SCAN_CHK;
      S_SCAN_CHK: begin
        if (!stat.ptr_at_end) begin
          state_next = S_SCAN_RD;
        end else if (stat.found || stat.hit) begin
          state_next = S_MATCH_RD;
        end else begin
          state_next = S_RESP; res_next = RES_NOT_FOUND;
        end
      end
      S_MATCH_RD: state_next = S_MATCH_CHK;
      S_MATCH_CHK: begin
        if (!stat.hit) begin
          state_next = S_MATCH_RD;
        end else if (stat.out_free) begin
          state_next = stat.hit_last ? S_IDLE : S_MATCH_RD;
        end
      end
      S_DISP_RD: state_next = S_DISP_CHK;
      S_DISP_CHK: begin
        if (stat.out_free) begin
          state_next = stat.ptr_at_end ? S_IDLE : S_DISP_RD;
        end
      end
      S_RESP: begin
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd         = '0;
    cmd.rd_addr = RA_PTR;
    cmd.res     = res;
    in_ready    = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready      = 1'b1;
        cmd.take_item = in_valid;
      end
      S_DECIDE: cmd.setup = 1'b1;
      S_INS_RD: begin
        if (stat.ptr_above_slot) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = RA_PTR_M1;
        end else begin
          cmd.wr_new  = 1'b1;
          cmd.cnt_inc = 1'b1;
        end
      end
      S_INS_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.ptr_dec  = 1'b1;
      end
      S_DEL_RD0:  cmd.rd_en = 1'b1;
      S_DEL_HOLD: cmd.hold_removed = 1'b1;
      S_DEL_RD: begin
        if (stat.ptr_at_end) begin
          cmd.cnt_dec = 1'b1;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = RA_PTR_P1;
        end
      end
      S_DEL_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.ptr_inc  = 1'b1;
      end
      S_SCAN_RD: cmd.rd_en = 1'b1;
      S_SCAN_CHK: begin
        cmd.scan_note = 1'b1;
        if (stat.ptr_at_end) begin
          cmd.ptr_clr = 1'b1;
        end else begin
          cmd.ptr_inc = 1'b1;
        end
      end
      S_MATCH_RD: cmd.rd_en = 1'b1;
      S_MATCH_CHK: begin
        cmd.res = RES_MATCH;
        if (!stat.hit) begin
          cmd.ptr_inc = 1'b1;
        end else if (stat.out_free) begin
          cmd.emit    = 1'b1;
          cmd.ptr_inc = !stat.hit_last;
        end
      end
      S_DISP_RD: cmd.rd_en = 1'b1;
      S_DISP_CHK: begin
        cmd.res = RES_ENTRY;
        if (stat.out_free) begin
          cmd.emit    = 1'b1;
          cmd.ptr_inc = !stat.ptr_at_end;
        end
      end
      S_RESP: cmd.emit = stat.out_free;
      default: cmd.emit = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

### sv/positional_array_table.sv
// ----------------------------------------------------------------------------
// Positional array table
// Ordered list of signed words with insert, delete, search and display.
// ----------------------------------------------------------------------------
// Requests arrive as words on the s_axis channel: tuser carries the operation
// (insert, delete, search, display) and tdata the one-based position and the
// value. Results leave on the m_axis channel, one word per result; tlast
// marks the final word of a request and tuser carries its status.
// Insert, delete and error requests give exactly one word; a search gives one
// word per matching index (or one not-found word); a display gives one word
// per stored entry (or one empty word).
// One request is worked at a time. The entries live in a memory with one read
// port, one write port and a registered read, so each step of a walk reads an
// entry in one state and uses it in the next.
// The result is held in an output register, and the next request is taken
// in the cycle after the last word of the previous one has been loaded. A
// stalled receiver holds the walk at the next result word until it is taken.
// Reset empties the list at once; no clearing pass is run.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_array_table (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata: position [6:0], value [38:7], zero pad [39]
  input  wire logic [pat_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // tuser: operation [1:0]
  input  wire logic [pat_pkg::OP_W-1:0]        s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // tdata: item_value [31:0], item_index [37:32], new_count [44:38], pad [47:45]
  output logic [pat_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
  output logic                                 m_axis_tlast,
  // tuser: status [1:0]
  output logic [pat_pkg::ST_W-1:0]             m_axis_tuser
);
  import pat_pkg::*;

  // Commands flow from the controller into the datapath; status flows back.
  pat_cmd_t  cmd;
  pat_stat_t stat;

  pat_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pat_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .in_op      (s_axis_tuser),
    .in_data    (s_axis_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_data   (m_axis_tdata),
    .out_last   (m_axis_tlast),
    .out_status (m_axis_tuser)
  );

endmodule

`default_nettype wire

### sv/pat_checker.sv
// ----------------------------------------------------------------------------
// Positional array table checker
// Port-level properties of the table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "positional_array_table_defines.svh"

module pat_sva (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          s_axis_tvalid,
  input wire logic                          s_axis_tready,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [pat_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input wire logic                          m_axis_tlast,
  input wire logic [pat_pkg::ST_W-1:0]      m_axis_tuser
);
  import pat_pkg::*;

  logic [IDX_W-1:0]                idx;
  logic [CNT_W-1:0]                cnt;
  logic                            in_acc;
  logic                            out_stall;
  logic [OUT_DATA_W+ST_W:0]        out_word;
  logic                            err_word;
  logic                            err_shape;
  logic                            ok_word;
  logic                            idx_ok;

  assign idx       = m_axis_tdata[DATA_W +: IDX_W];
  assign cnt       = m_axis_tdata[DATA_W + IDX_W +: CNT_W];
  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign out_word  = {m_axis_tuser, m_axis_tlast, m_axis_tdata};
  assign err_word  = m_axis_tvalid && (m_axis_tuser == ST_BAD_POS || m_axis_tuser == ST_FULL);
  assign err_shape = m_axis_tlast && (m_axis_tdata[DATA_W-1:0] == '0) && (idx == '0);
  assign ok_word   = m_axis_tvalid && (m_axis_tuser == ST_OK);
  assign idx_ok    = (CNT_W'(idx) <= cnt) && (cnt <= CNT_W'(DEPTH));

  // A request is worked alone: the input closes right after a word is taken.
  `PAT_ASSERT_NEXT(a_busy_after_accept, in_acc, !s_axis_tready, "input open after accept")

  `PAT_ASSERT_NEXT(a_hold_stalled, out_stall, m_axis_tvalid && $stable(out_word), "stalled result changed")

  // Position and full errors are single zero-valued words.
  `PAT_ASSERT_NOW(a_error_single, err_word, err_shape, "error word malformed")

  // A good result index is at most the count of the list after the request.
  `PAT_ASSERT_NOW(a_index_in_list, ok_word, idx_ok, "index beyond count")

endmodule

bind positional_array_table pat_sva u_pat_sva (.*);

`default_nettype wire
